// ----- sv/teq_pkg.sv -----
// Package for the timed event queue: widths, mode and status codes.
package teq_pkg;
   localparam int QueueDepthDefault = 16;
   localparam int ResultLimit = 16;
   localparam int TimeWidth = 48;
   localparam int IdWidth = 32;
   localparam int KeyWidth = 16;

   localparam logic [2:0] MODE_POST_ABS = 3'd0;
   localparam logic [2:0] MODE_POST_DLY = 3'd1;
   localparam logic [2:0] MODE_CAN_ID = 3'd2;
   localparam logic [2:0] MODE_CAN_TYPE = 3'd3;
   localparam logic [2:0] MODE_CAN_MSG = 3'd4;
   localparam logic [2:0] MODE_CAN_ALL = 3'd5;
   localparam logic [2:0] MODE_TICK = 3'd6;
   localparam logic [2:0] MODE_UNUSED = 3'd7;

   localparam logic [1:0] ST_DONE = 2'd0;
   localparam logic [1:0] ST_FULL = 2'd1;
   localparam logic [1:0] ST_NONE = 2'd2;
   localparam logic [1:0] ST_FIRED = 2'd3;

   localparam logic signed [TimeWidth-1:0] TimeMax = {1'b0, {(TimeWidth-1){1'b1}}};

   typedef struct packed {
      logic [TimeWidth-1:0] etime;
      logic [IdWidth-1:0] id;
      logic [KeyWidth-1:0] etype;
      logic [KeyWidth-1:0] emsg;
   } entry_type;
endpackage

// ----- sv/timed_event_queue_core.sv -----
// Top level of the timed event queue: sequencer over a single-write, single-read entry RAM.
// Post walks from the tail shifting later entries up, then writes the new one;
// cancel walks all entries and compacts the kept ones; tick fires due entries
// from the head, one response each up to ResultLimit, then compacts the rest;
// cancel-all and unused modes answer directly. Requests are taken one at a time.
// Reset: synchronous, active high; clears occupancy, sets id counter to 1.
module timed_event_queue_core
   import teq_pkg::*;
#(
   parameter int QueueDepth = QueueDepthDefault
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [2:0]                  req_mode,
   input  logic signed [TimeWidth-1:0] req_event_time,
   input  logic signed [TimeWidth-1:0] req_now_time,
   input  logic [KeyWidth-1:0]         req_event_type,
   input  logic [KeyWidth-1:0]         req_event_msg,
   input  logic [IdWidth-1:0]          req_cancel_id,
   input  logic                        req_first_only,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [1:0]                  rsp_status,
   output logic [IdWidth-1:0]          rsp_out_id,
   output logic [KeyWidth-1:0]         rsp_out_type,
   output logic [KeyWidth-1:0]         rsp_out_msg,
   output logic [4:0]                  rsp_removed_count,
   output logic                        rsp_head_changed,
   output logic                        rsp_last
);
   localparam int AW = $clog2(QueueDepth);
   localparam int CW = $clog2(QueueDepth + 1);
   localparam int EW = $bits(entry_type);

   // Sequencer states
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_READ = 3'd1; // RAM read issued, data next cycle
   localparam logic [2:0] S_EXAM = 3'd2; // examine the entry just read
   localparam logic [2:0] S_MOVE = 3'd3; // write the moved entry
   localparam logic [2:0] S_RESP = 3'd4; // hold result until taken
   localparam logic [2:0] S_INS = 3'd5;  // write new entry at its slot

   logic [2:0] state_ff, state_in;
   logic [CW-1:0] occ_ff, occ_in;
   logic [IdWidth-1:0] nid_ff, nid_in;

   // Latched request
   logic [2:0] mode_ff, mode_in;
   logic signed [TimeWidth-1:0] t_ff, t_in;      // post time
   logic signed [TimeWidth-1:0] now_ff, now_in;
   logic [KeyWidth-1:0] ktype_ff, ktype_in, kmsg_ff, kmsg_in;
   logic [IdWidth-1:0] kid_ff, kid_in;
   logic first_ff, first_in;

   // Walk state
   logic [CW-1:0] idx_ff, idx_in;   // read index
   logic [CW-1:0] wr_ff, wr_in;     // compaction write index / shift index
   logic [CW-1:0] rem_ff, rem_in;   // removed count
   logic stop_ff, stop_in;          // first-only cancel already hit
   logic [4:0] fired_ff, fired_in;
   logic pend_ff, pend_in;          // fired item held until next entry is seen

   // Result register
   logic [1:0] r_status_ff, r_status_in;
   logic [IdWidth-1:0] r_id_ff, r_id_in;
   logic [KeyWidth-1:0] r_type_ff, r_type_in, r_msg_ff, r_msg_in;
   logic [4:0] r_rem_ff, r_rem_in;
   logic r_head_ff, r_head_in, r_last_ff, r_last_in;
   logic [2:0] after_ff, after_in; // state to enter once the result is taken

   // RAM port
   logic ram_we;
   logic [AW-1:0] ram_wa, ram_ra;
   entry_type ram_wd, ram_rd;

   teq_ram #(.Width(EW), .Depth(QueueDepth)) u_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_wa),
      .wr_data(ram_wd),
      .rd_addr(ram_ra),
      .rd_data(ram_rd)
   );

   logic req_take;
   assign req_stall = (state_ff != S_IDLE);
   assign req_take = req_valid && !req_stall;

   // Delay sum with saturation
   logic signed [TimeWidth:0] dsum;
   assign dsum = {req_now_time[TimeWidth-1], req_now_time}
               + {req_event_time[TimeWidth-1], req_event_time};

   logic is_post, is_cancel, hit, due, ge_t;
   assign is_post = (mode_ff == MODE_POST_ABS) || (mode_ff == MODE_POST_DLY);
   assign is_cancel = (mode_ff == MODE_CAN_ID) || (mode_ff == MODE_CAN_TYPE)
                   || (mode_ff == MODE_CAN_MSG);

   always_comb begin
      case (mode_ff)
         MODE_CAN_ID:   hit = (ram_rd.id == kid_ff);
         MODE_CAN_TYPE: hit = (ram_rd.etype == ktype_ff);
         default:       hit = (ram_rd.emsg == kmsg_ff);
      endcase
   end
   assign due = ($signed(ram_rd.etime) <= now_ff) || ($signed(ram_rd.etime) <= 0)
             || ($signed(ram_rd.etime) == TimeMax);
   // post walks from the tail: shift entry right while its time > t
   assign ge_t = (t_ff >= $signed(ram_rd.etime));

   always_comb begin
      state_in = state_ff;
      occ_in = occ_ff;
      nid_in = nid_ff;
      mode_in = mode_ff;
      t_in = t_ff;
      now_in = now_ff;
      ktype_in = ktype_ff;
      kmsg_in = kmsg_ff;
      kid_in = kid_ff;
      first_in = first_ff;
      idx_in = idx_ff;
      wr_in = wr_ff;
      rem_in = rem_ff;
      stop_in = stop_ff;
      fired_in = fired_ff;
      pend_in = pend_ff;
      r_status_in = r_status_ff;
      r_id_in = r_id_ff;
      r_type_in = r_type_ff;
      r_msg_in = r_msg_ff;
      r_rem_in = r_rem_ff;
      r_head_in = r_head_ff;
      r_last_in = r_last_ff;
      after_in = after_ff;
      ram_we = 1'b0;
      ram_wa = wr_ff[AW-1:0];
      ram_wd = ram_rd;
      ram_ra = idx_ff[AW-1:0];

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               mode_in = req_mode;
               now_in = req_now_time;
               ktype_in = req_event_type;
               kmsg_in = req_event_msg;
               kid_in = req_cancel_id;
               first_in = req_first_only;
               t_in = req_event_time;
               if (req_mode == MODE_POST_DLY && req_event_time > 0) begin
                  t_in = (dsum > $signed({1'b0, TimeMax})) ? TimeMax
                       : dsum[TimeWidth-1:0];
               end
               rem_in = '0;
               stop_in = 1'b0;
               fired_in = '0;
               pend_in = 1'b0;
               r_status_in = ST_NONE;
               r_id_in = '0;
               r_type_in = '0;
               r_msg_in = '0;
               r_rem_in = '0;
               r_head_in = 1'b0;
               r_last_in = 1'b1;
               after_in = S_IDLE;
               state_in = S_RESP;
               case (req_mode)
                  MODE_POST_ABS, MODE_POST_DLY: begin
                     if (occ_ff >= CW'(QueueDepth)) begin
                        r_status_in = ST_FULL;
                     end else begin
                        // walk from tail downward
                        wr_in = occ_ff;
                        idx_in = occ_ff - 1'b1;
                        state_in = (occ_ff == '0) ? S_INS : S_READ;
                     end
                  end
                  MODE_CAN_ID, MODE_CAN_TYPE, MODE_CAN_MSG: begin
                     idx_in = '0;
                     wr_in = '0;
                     state_in = (occ_ff == '0) ? S_RESP : S_READ;
                  end
                  MODE_CAN_ALL: begin
                     r_status_in = ST_DONE;
                     r_rem_in = 5'(occ_ff);
                     occ_in = '0;
                  end
                  MODE_TICK: begin
                     idx_in = '0;
                     state_in = (occ_ff == '0) ? S_RESP : S_READ;
                  end
                  default: begin
                  end
               endcase
            end
         end

         S_READ: begin
            state_in = S_EXAM;
         end

         S_EXAM: begin
            if (is_post) begin
               if (!ge_t) begin
                  // shift this entry one slot right
                  ram_we = 1'b1;
                  ram_wa = wr_ff[AW-1:0];
                  wr_in = wr_ff - 1'b1;
                  if (idx_ff == '0) begin
                     state_in = S_INS;
                  end else begin
                     idx_in = idx_ff - 1'b1;
                     state_in = S_READ;
                  end
               end else begin
                  state_in = S_INS;
               end
            end else if (is_cancel) begin
               if (hit && !stop_ff) begin
                  rem_in = rem_ff + 1'b1;
                  r_status_in = ST_DONE;
                  r_id_in = ram_rd.id;
                  r_type_in = ram_rd.etype;
                  r_msg_in = ram_rd.emsg;
                  if (first_ff) stop_in = 1'b1;
               end else begin
                  // keep: compact down
                  ram_we = (wr_ff != idx_ff);
                  wr_in = wr_ff + 1'b1;
               end
               if (idx_ff + 1'b1 >= occ_ff) begin
                  occ_in = occ_ff - (rem_in - rem_ff) - rem_ff;
                  r_rem_in = 5'(rem_in);
                  state_in = S_RESP;
               end else begin
                  idx_in = idx_ff + 1'b1;
                  state_in = S_READ;
               end
            end else if (pend_ff) begin
               // a fired item waits in the result register; it is the last
               // one unless the entry now read is due as well
               pend_in = 1'b0;
               r_last_in = !due;
               after_in = due ? S_EXAM : S_MOVE;
               state_in = S_RESP;
            end else begin
               // tick: head sits at idx_ff, entries below are already fired
               if (due) begin
                  r_status_in = ST_FIRED;
                  r_id_in = ram_rd.id;
                  r_type_in = ram_rd.etype;
                  r_msg_in = ram_rd.emsg;
                  fired_in = fired_ff + 1'b1;
                  idx_in = idx_ff + 1'b1;
                  if (idx_ff + 1'b1 >= occ_ff || fired_ff == 5'(ResultLimit - 1)) begin
                     r_last_in = 1'b1;
                     after_in = S_MOVE;
                     state_in = S_RESP;
                  end else begin
                     // read ahead before the item goes out
                     pend_in = 1'b1;
                     state_in = S_READ;
                  end
               end else if (fired_ff == '0) begin
                  state_in = S_RESP;
               end else begin
                  state_in = S_MOVE;
               end
            end
         end

         S_INS: begin
            ram_we = 1'b1;
            ram_wa = wr_ff[AW-1:0];
            ram_wd.etime = t_ff;
            ram_wd.id = nid_ff;
            ram_wd.etype = ktype_ff;
            ram_wd.emsg = kmsg_ff;
            r_status_in = ST_DONE;
            r_id_in = nid_ff;
            r_head_in = (wr_ff == '0);
            nid_in = (nid_ff + 1'b1 == '0) ? IdWidth'(1) : nid_ff + 1'b1;
            occ_in = occ_ff + 1'b1;
            state_in = S_RESP;
         end

         S_MOVE: begin
            // tick compaction: drop the fired prefix by moving the tail down.
            // wr_ff counts destination, idx_ff the source being read.
            if (rem_ff == '0) begin
               // first entry into the sweep
               rem_in = CW'(1);
               wr_in = '0;
               if (idx_ff >= occ_ff) begin
                  occ_in = '0;
                  state_in = S_IDLE;
               end else begin
                  ram_ra = idx_ff[AW-1:0];
               end
            end else if (rem_ff == CW'(1)) begin
               rem_in = CW'(2);
               ram_ra = idx_ff[AW-1:0];
            end else begin
               ram_we = 1'b1;
               wr_in = wr_ff + 1'b1;
               idx_in = idx_ff + 1'b1;
               ram_ra = idx_in[AW-1:0];
               rem_in = CW'(1);
               if (idx_ff + 1'b1 >= occ_ff) begin
                  occ_in = wr_ff + 1'b1;
                  state_in = S_IDLE;
               end
            end
         end

         S_RESP: begin
            if (!rsp_stall) begin
               state_in = after_ff;
               if (after_ff == S_MOVE) begin
                  rem_in = '0;
                  wr_in = '0;
               end
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         occ_ff <= '0;
         nid_ff <= IdWidth'(1);
      end else begin
         state_ff <= state_in;
         occ_ff <= occ_in;
         nid_ff <= nid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff <= mode_in;
      t_ff <= t_in;
      now_ff <= now_in;
      ktype_ff <= ktype_in;
      kmsg_ff <= kmsg_in;
      kid_ff <= kid_in;
      first_ff <= first_in;
      idx_ff <= idx_in;
      wr_ff <= wr_in;
      rem_ff <= rem_in;
      stop_ff <= stop_in;
      fired_ff <= fired_in;
      pend_ff <= pend_in;
      r_status_ff <= r_status_in;
      r_id_ff <= r_id_in;
      r_type_ff <= r_type_in;
      r_msg_ff <= r_msg_in;
      r_rem_ff <= r_rem_in;
      r_head_ff <= r_head_in;
      r_last_ff <= r_last_in;
      after_ff <= after_in;
   end

   assign rsp_valid = (state_ff == S_RESP);
   assign rsp_status = r_status_ff;
   assign rsp_out_id = r_id_ff;
   assign rsp_out_type = r_type_ff;
   assign rsp_out_msg = r_msg_ff;
   assign rsp_removed_count = r_rem_ff;
   assign rsp_head_changed = r_head_ff;
   assign rsp_last = r_last_ff;
endmodule

// ----- sv/teq_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module teq_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule
